FILE: rtl/core/pdh_pkg.sv
// Shared types and constants for the B-before-A pair distance histogram.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pdh_pkg;

  localparam int unsigned DIST_W     = 12;
  localparam int unsigned DIST_DEPTH = 1 << DIST_W;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned SYM_W      = 8;

  localparam logic [SYM_W-1:0] SYM_A = 8'h41;
  localparam logic [SYM_W-1:0] SYM_B = 8'h42;

  // Count readout: first level picks one slot in each group, second picks the group.
  localparam int unsigned LO_W     = 8;
  localparam int unsigned HI_W     = DIST_W - LO_W;
  localparam int unsigned NUM_GRP  = 1 << HI_W;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } pdh_action_e;

  // Per-cycle command broadcast to every distance cell.
  typedef struct packed {
    logic shift;
    logic is_a;
    logic is_b;
    logic clear;
  } pdh_ctrl_t;

endpackage

FILE: rtl/core/pdh_cell.sv
// One distance cell: a B-mark tap of the symbol shift line and a saturating
// pair counter for its distance. Depends on pdh_pkg.
`timescale 1ns / 1ps

module pdh_cell
  import pdh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdh_ctrl_t          ctrl_i,
  input  logic               mark_i,
  output logic               mark_o,
  output logic [COUNT_W-1:0] count_o
);

  logic               mark_q, mark_d;
  logic [COUNT_W-1:0] count_q, count_d;

  always_comb begin
    mark_d  = mark_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      mark_d  = 1'b0;
      count_d = '0;
    end else if (ctrl_i.shift) begin
      mark_d = mark_i;
      // an incoming A pairs with the B this cell holds; saturate at full scale
      if (ctrl_i.is_a && mark_q && (count_q != '1)) begin
        count_d = count_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= 1'b0;
      count_q <= '0;
    end else begin
      mark_q  <= mark_d;
      count_q <= count_d;
    end
  end

  assign mark_o  = mark_q;
  assign count_o = count_q;

endmodule

FILE: rtl/core/pdh_chain.sv
// Row of distance cells; cell k holds the mark of the symbol k positions back
// and the pair count for distance k. Depends on pdh_pkg and pdh_cell.
`timescale 1ns / 1ps

module pdh_chain
  import pdh_pkg::*;
#(
  parameter int unsigned NCELL = 4095
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdh_ctrl_t          ctrl_i,
  output logic [COUNT_W-1:0] counts_o [DIST_DEPTH]
);

  logic mark_w [NCELL];

  assign mark_w[0] = ctrl_i.is_b;

  for (genvar k = 0; k < DIST_DEPTH; k++) begin : g_slot
    if ((k == 0) || (k > NCELL)) begin : g_zero
      assign counts_o[k] = '0;
    end else if (k == NCELL) begin : g_last
      pdh_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .mark_i  (mark_w[k-1]),
        .mark_o  (),
        .count_o (counts_o[k])
      );
    end else begin : g_cell
      pdh_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .mark_i  (mark_w[k-1]),
        .mark_o  (mark_w[k]),
        .count_o (counts_o[k])
      );
    end
  end

endmodule

FILE: rtl/core/pdh_rdsel.sv
// Two-level registered readout of the pair counters by distance.
// Depends on pdh_pkg.
`timescale 1ns / 1ps

module pdh_rdsel
  import pdh_pkg::*;
(
  input  logic               clk_i,
  input  logic [COUNT_W-1:0] counts_i [DIST_DEPTH],
  input  logic               capture_i,
  input  logic [DIST_W-1:0]  distance_i,
  output logic [COUNT_W-1:0] count_o
);

  logic [COUNT_W-1:0] grp_q [NUM_GRP];
  logic [HI_W-1:0]    hi_q;

  // snapshot one slot per group at request time
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_q[g] <= counts_i[{HI_W'(g), distance_i[LO_W-1:0]}];
      end
      hi_q <= distance_i[DIST_W-1:LO_W];
    end
  end

  assign count_o = grp_q[hi_q];

endmodule

FILE: rtl/core/ab_pair_distance_histogram.sv
// B-before-A pair distance histogram: a load moves one symbol into the cell row
// and updates every distance counter in the same cycle; a load to a full row only flags overflow.
// A read snapshots its counters into the two-level readout, then moves to the result register
// once the output is free; the input stalls only while a read sits behind a stalled result.
// Reset (async, active low) and a clear request both empty marks, counters,
// length and the overflow flag at once; no clearing pass is needed.
`timescale 1ns / 1ps

module ab_pair_distance_histogram
  import pdh_pkg::*;
#(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic [DIST_W-1:0]  distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] count_o,
  output logic               overflowed_o
);

  localparam int unsigned NCELL = (MAX_LEN - 1 < DIST_DEPTH - 1) ? MAX_LEN - 1
                                                                   : DIST_DEPTH - 1;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  pdh_action_e        act;
  pdh_ctrl_t          ctrl;
  logic               accept, full, rd_start, rd_hit, out_free, move;
  logic [COUNT_W-1:0] counts [DIST_DEPTH];
  logic [COUNT_W-1:0] sel_count;

  logic [LEN_W-1:0]   len_q, len_d;
  logic               drop_q, drop_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_hit_q;
  logic               rd_flag_q;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] count_q;
  logic               ovf_q;

  assign act      = pdh_action_e'(action_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign move     = rd_valid_q && out_free;
  assign in_ready_o = !rd_valid_q || out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign full     = (len_q == LEN_W'(MAX_LEN));
  assign rd_start = accept && (act == ACT_READ);
  assign rd_hit   = (distance_i != '0) && (CMP_W'(distance_i) < CMP_W'(len_q));

  always_comb begin
    ctrl.shift = accept && (act == ACT_LOAD) && !full;
    ctrl.is_a  = (symbol_i == SYM_A);
    ctrl.is_b  = (symbol_i == SYM_B);
    ctrl.clear = accept && (act == ACT_CLEAR);
  end

  pdh_chain #(
    .NCELL (NCELL)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .counts_o (counts)
  );

  pdh_rdsel u_rdsel (
    .clk_i      (clk_i),
    .counts_i   (counts),
    .capture_i  (rd_start),
    .distance_i (distance_i),
    .count_o    (sel_count)
  );

  always_comb begin
    len_d  = len_q;
    drop_d = drop_q;
    if (ctrl.clear) begin
      len_d  = '0;
      drop_d = 1'b0;
    end else if (ctrl.shift) begin
      len_d = len_q + LEN_W'(1);
    end else if (accept && (act == ACT_LOAD)) begin
      drop_d = 1'b1;
    end

    rd_valid_d = rd_valid_q;
    if (rd_start) begin
      rd_valid_d = 1'b1;
    end else if (move) begin
      rd_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      drop_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      drop_q      <= drop_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (rd_start) begin
      rd_hit_q  <= rd_hit;
      rd_flag_q <= drop_q;
    end
    if (move) begin
      count_q <= rd_hit_q ? sel_count : '0;
      ovf_q   <= rd_flag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign count_o      = count_q;
  assign overflowed_o = ovf_q;

endmodule

FILE: rtl/core/pdh_checker.sv
// Port-level checks for ab_pair_distance_histogram, attached by bind.
// Depends on pdh_pkg.
`timescale 1ns / 1ps

module pdh_checker
  import pdh_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         action_i,
  input logic [SYM_W-1:0]   symbol_i,
  input logic [DIST_W-1:0]  distance_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] count_o,
  input logic               overflowed_o
);

  logic read_acc;
  assign read_acc = in_valid_i && in_ready_o && (action_i == ACT_READ);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(count_o) && $stable(overflowed_o))
    else $error("result changed while stalled");

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(action_i) && $stable(symbol_i) && $stable(distance_i))
    else $error("request changed while stalled");

  // input back-pressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // a fresh result traces back to an accepted read request through the readout registers
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(read_acc, 2))
    else $error("result without a matching read request");

endmodule

bind ab_pair_distance_histogram pdh_checker u_pdh_checker (.*);

FILE: bench/tb_ab_pair_distance_histogram.sv
// Self-checking bench for ab_pair_distance_histogram: directed rows and random
// symbol runs, each result checked against a pair-count predictor in the bench
// or a typed row's count; depends on pdh_pkg and ab_pair_distance_histogram.
`timescale 1ns / 1ps

module tb_ab_pair_distance_histogram;
  import pdh_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned HIST_CAP       = 4096;
  localparam int unsigned N_DIRECTED     = 24;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    pdh_action_e        act;
    logic [SYM_W-1:0]   sym;
    logic [DIST_W-1:0]  distance;
    logic               typed;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } hist_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } count_rec_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i     = ACT_NONE;
  logic [SYM_W-1:0]   symbol_i     = '0;
  logic [DIST_W-1:0]  distance_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [COUNT_W-1:0] count_o;
  logic               overflowed_o;

  hist_req_t  req_q[$];
  count_rec_t count_q[$];
  hist_req_t  directed_rows[N_DIRECTED];
  hist_req_t  shown_req = '0;
  hist_req_t  taken_req;
  count_rec_t seen_result;
  logic       in_fire  = 1'b0;
  logic       out_fire = 1'b0;
  int unsigned err_count = 0;

  // predictor state
  int unsigned        hist_len;
  logic               hist_dropped;
  logic [COUNT_W-1:0] pair_hist[DIST_DEPTH];
  int unsigned        b_positions[$];

  ab_pair_distance_histogram #(
    .MAX_LEN(HIST_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .symbol_i    (symbol_i),
    .distance_i  (distance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .count_o     (count_o),
    .overflowed_o(overflowed_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void hist_clear();
    foreach (pair_hist[k]) pair_hist[k] = '0;
    b_positions.delete();
    hist_len     = 0;
    hist_dropped = 1'b0;
  endfunction

  // Apply one request to the predictor; return 1 when it yields a result.
  function automatic bit histogram_apply(input hist_req_t r, output count_rec_t res);
    int unsigned d;
    res.count = '0;
    res.ovf   = hist_dropped;
    case (r.act)
      ACT_LOAD: begin
        if (hist_len >= HIST_CAP) begin
          hist_dropped = 1'b1;
        end else begin
          if (r.sym == SYM_A) begin
            foreach (b_positions[k]) begin
              d = hist_len - b_positions[k];
              // counters saturate at full scale
              if (d < DIST_DEPTH && pair_hist[d] != COUNT_MAX) pair_hist[d]++;
            end
          end
          if (r.sym == SYM_B) b_positions.push_back(hist_len);
          hist_len++;
        end
        return 1'b0;
      end
      ACT_READ: begin
        if (r.distance != 0 && r.distance < hist_len) res.count = pair_hist[r.distance];
        return 1'b1;
      end
      ACT_CLEAR: begin
        hist_clear();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void queue_req(pdh_action_e a, logic [SYM_W-1:0] s,
                                    logic [DIST_W-1:0] d);
    hist_req_t r;
    r          = '0;
    r.act      = a;
    r.sym      = s;
    r.distance = d;
    req_q.push_back(r);
  endfunction

  // Favor the two significant characters.
  function automatic logic [SYM_W-1:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return SYM_A;
    if (r < 8) return SYM_B;
    return SYM_W'($urandom);
  endfunction

  // Mostly distances from zero to one past the loaded length, sometimes anywhere.
  function automatic logic [DIST_W-1:0] pick_distance(int unsigned len);
    if ($urandom_range(0, 4) == 0) return DIST_W'($urandom);
    return DIST_W'($urandom_range(0, (len + 1 > DIST_DEPTH - 1) ? DIST_DEPTH - 1 : len + 1));
  endfunction

  task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    hist_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (gap_left != 0 || req_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        shown_req  <= nxt;
        in_valid_i <= 1'b1;
        action_i   <= nxt.act;
        symbol_i   <= nxt.sym;
        distance_i <= nxt.distance;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: the stall pattern switches between randomly chosen modes.
  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_left  = 0;
  int unsigned rx_phase = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= (rx_phase % 4 == 0);
      default:   out_ready_i <= (rx_phase % 4 != 0);
    endcase
  end

  // Sample handshakes mid-cycle, where inputs and outputs are both settled.
  always @(negedge clk_i) begin
    in_fire           = in_valid_i && (in_ready_o === 1'b1);
    taken_req         = shown_req;
    out_fire          = (out_valid_o === 1'b1) && out_ready_i;
    seen_result.count = count_o;
    seen_result.ovf   = overflowed_o;
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    count_rec_t want;
    if (in_fire) begin
      if (histogram_apply(taken_req, want)) begin
        if (taken_req.typed) begin
          want.count = taken_req.count;
          want.ovf   = taken_req.ovf;
        end
        count_q.push_back(want);
      end
    end
    if (out_fire) begin
      if (count_q.size() == 0) begin
        report_mismatch("result with no read pending", seen_result.count, '0);
      end else begin
        want = count_q.pop_front();
        if (seen_result.count !== want.count)
          report_mismatch("count", seen_result.count, want.count);
        if (seen_result.ovf !== want.ovf)
          report_mismatch("overflowed", COUNT_W'(seen_result.ovf), COUNT_W'(want.ovf));
      end
    end
    if (!rst_ni || in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ab_pair_distance_histogram verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    int unsigned gen_len;
    int unsigned rand_items;
    int unsigned run_len;

    hist_clear();

    //               act        sym      distance  typed count   ovf
    directed_rows = '{
      '{ACT_READ,  8'h00,  12'd0,    1'b1, 12'd0, 1'b0},  // after reset
      '{ACT_READ,  8'hFF,  12'd4095, 1'b1, 12'd0, 1'b0},
      '{ACT_NONE,  SYM_A,  12'd5,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  SYM_B,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  SYM_A,  12'd4095, 1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd1,    1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd0,    1'b1, 12'd0, 1'b0},  // distance zero
      '{ACT_READ,  8'h00,  12'd2,    1'b1, 12'd0, 1'b0},  // not below length
      '{ACT_LOAD,  8'hFF,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  8'h00,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  SYM_A,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd4,    1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd5,    1'b1, 12'd0, 1'b0},  // not below length
      '{ACT_LOAD,  8'h61,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  SYM_B,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  8'h43,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  8'h40,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd1,    1'b0, 12'd0, 1'b0},
      '{ACT_CLEAR, 8'hFF,  12'd4095, 1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd1,    1'b1, 12'd0, 1'b0},  // after clear
      '{ACT_LOAD,  SYM_B,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_LOAD,  SYM_A,  12'd0,    1'b0, 12'd0, 1'b0},
      '{ACT_READ,  8'h00,  12'd1,    1'b0, 12'd0, 1'b0},
      '{ACT_NONE,  8'h00,  12'd0,    1'b0, 12'd0, 1'b0}
    };
    for (k = 0; k < N_DIRECTED; k++) req_q.push_back(directed_rows[k]);

    // Random symbol runs with reads mixed in and an occasional clear.
    gen_len    = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_req(ACT_CLEAR, SYM_W'($urandom), DIST_W'($urandom));
        gen_len = 0;
        rand_items++;
      end
      run_len = $urandom_range(1, 40);
      for (k = 0; k < run_len; k++) begin
        queue_req(ACT_LOAD, pick_symbol(), DIST_W'($urandom));
        gen_len++;
        rand_items++;
        if ($urandom_range(0, 3) == 0) begin
          queue_req(ACT_READ, SYM_W'($urandom), pick_distance(gen_len));
          rand_items++;
        end
        if ($urandom_range(0, 29) == 0)
          queue_req(ACT_NONE, SYM_W'($urandom), DIST_W'($urandom));
      end
      repeat ($urandom_range(1, 4)) begin
        queue_req(ACT_READ, SYM_W'($urandom), pick_distance(gen_len));
        rand_items++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i || count_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ab_pair_distance_histogram verification clean");
    end else begin
      $display("ab_pair_distance_histogram verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pdh_pkg.sv
rtl/core/pdh_cell.sv
rtl/core/pdh_chain.sv
rtl/core/pdh_rdsel.sv
rtl/core/ab_pair_distance_histogram.sv
rtl/core/pdh_checker.sv
bench/tb_ab_pair_distance_histogram.sv
